@@ src/llba_pkg.sv @@
// Shared constants and types for the least-loaded bin assignment block.
// No dependencies; compile before the interfaces and modules.
package llba_pkg;

   localparam int SIZE_W = 16;
   localparam int LOAD_W = 32;
   localparam int CNT_W  = 16;
   localparam int FID_W  = 4;
   localparam int CFG_W  = 5;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HEAD  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_PLACE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

@@ src/llba_intf.sv @@
// Valid/ready channel interfaces for the file request and folder response.
// Depends on llba_pkg for the field widths.
interface llba_req_if;
   import llba_pkg::*;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] file_size;
   modport source (output valid, output file_size, input ready);
   modport sink   (input valid, input file_size, output ready);
endinterface

interface llba_rsp_if;
   import llba_pkg::*;
   logic              valid;
   logic              ready;
   logic [FID_W-1:0]  folder_id;
   logic [LOAD_W-1:0] folder_load;
   logic [CNT_W-1:0]  folder_files;
   modport source (output valid, output folder_id, output folder_load, output folder_files,
                   input ready);
   modport sink   (input valid, input folder_id, input folder_load, input folder_files,
                   output ready);
endinterface

@@ src/least_loaded_bin_assign.sv @@
// Least-loaded bin assignment: the head of the sorted folder order takes each file.
// The head folder is updated, then one compare per cycle walks the order, held in a
// single RAM, up to the insertion position. A new file is taken only after the previous
// file's response is registered, which waits while a finished response waits for rsp
// ready.
// Reset (synchronous, active high) and every CSR write restore ascending ids, zero loads.
module least_loaded_bin_assign #(
   parameter int MAX_FOLDERS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [llba_pkg::CFG_W-1:0] csr_wdata,
   llba_req_if.sink               req,
   llba_rsp_if.source             rsp
);
   import llba_pkg::*;

   localparam int PW      = (MAX_FOLDERS > 1) ? $clog2(MAX_FOLDERS) : 1;
   localparam int NW      = $clog2(MAX_FOLDERS + 1) > 0 ? $clog2(MAX_FOLDERS + 1) : 1;
   localparam int EW      = PW + LOAD_W + CNT_W;
   localparam int RESET_N = (MAX_FOLDERS < 16) ? MAX_FOLDERS : 16;

   state_type state_ff, state_in;

   logic [NW-1:0]          n_ff, n_in, cfg_n, n_m1;
   logic [MAX_FOLDERS-1:0] valid_ff, valid_in;
   logic                   valid_rd_ff, valid_rd_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [PW-1:0]          cur_id_ff, cur_id_in;
   logic [LOAD_W-1:0]      cur_load_ff, cur_load_in;
   logic [CNT_W-1:0]       cur_cnt_ff, cur_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [LOAD_W-1:0]      rsp_load_ff, rsp_load_in;
   logic [CNT_W-1:0]       rsp_cnt_ff, rsp_cnt_in;

   logic                   wr_en;
   logic [PW-1:0]          wr_addr;
   logic [EW-1:0]          wr_data, rd_data;

   logic [PW-1:0]          ent_id;
   logic [LOAD_W-1:0]      ent_load;
   logic [CNT_W-1:0]       ent_cnt;
   logic [LOAD_W:0]        sum;
   logic                   ent_after;
   logic                   last_pos;
   logic [PW+FID_W-1:0]    id_ext;

   llba_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_FOLDERS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   // An entry never written since the last clear reads as its reset value.
   always_comb begin
      if (valid_rd_ff) begin
         ent_id   = rd_data[EW-1 -: PW];
         ent_load = rd_data[LOAD_W+CNT_W-1 -: LOAD_W];
         ent_cnt  = rd_data[CNT_W-1:0];
      end else begin
         ent_id   = pos_ff;
         ent_load = '0;
         ent_cnt  = '0;
      end
   end

   always_comb begin
      if (csr_wdata == '0) begin
         cfg_n = NW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_FOLDERS)) begin
         cfg_n = NW'(MAX_FOLDERS);
      end else begin
         cfg_n = NW'(csr_wdata);
      end
   end

   assign n_m1      = n_ff - NW'(1);
   assign last_pos  = (pos_ff == n_m1[PW-1:0]);
   assign sum       = {1'b0, ent_load} + {{(LOAD_W+1-SIZE_W){1'b0}}, size_ff};
   assign ent_after = (ent_load > cur_load_ff) ||
                      ((ent_load == cur_load_ff) && (ent_cnt >= cur_cnt_ff));
   assign id_ext    = {{FID_W{1'b0}}, cur_id_ff};

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      valid_in     = valid_ff;
      pos_in       = '0;
      size_in      = size_ff;
      cur_id_in    = cur_id_ff;
      cur_load_in  = cur_load_ff;
      cur_cnt_in   = cur_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff - PW'(1);
      wr_data      = {ent_id, ent_load, ent_cnt};

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               size_in  = req.file_size;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            // Saturating update of the head folder.
            cur_id_in   = ent_id;
            cur_load_in = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
            cur_cnt_in  = (ent_cnt == CNT_MAX) ? ent_cnt : ent_cnt + CNT_W'(1);
            if (n_ff == NW'(1)) begin
               state_in = ST_PLACE;
            end else begin
               pos_in   = PW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            wr_en = 1'b1;
            if (ent_after) begin
               wr_data  = {cur_id_ff, cur_load_ff, cur_cnt_ff};
               state_in = ST_DONE;
            end else if (last_pos) begin
               pos_in   = pos_ff;
               state_in = ST_PLACE;
            end else begin
               // Shift this entry down one position and advance.
               pos_in = pos_ff + PW'(1);
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = n_m1[PW-1:0];
            wr_data  = {cur_id_ff, cur_load_ff, cur_cnt_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ext[FID_W-1:0];
               rsp_load_in  = cur_load_ff;
               rsp_cnt_in   = cur_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (csr_we) begin
         n_in     = cfg_n;
         valid_in = '0;
      end
      valid_rd_in = csr_we ? 1'b0 : valid_in[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= NW'(RESET_N);
         valid_ff     <= '0;
         valid_rd_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         valid_ff     <= valid_in;
         valid_rd_ff  <= valid_rd_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      cur_id_ff   <= cur_id_in;
      cur_load_ff <= cur_load_in;
      cur_cnt_ff  <= cur_cnt_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_load_ff <= rsp_load_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.folder_id    = rsp_id_ff;
   assign rsp.folder_load  = rsp_load_ff;
   assign rsp.folder_files = rsp_cnt_ff;

   a_accept_to_head: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_HEAD))
      else $error("request transfer did not start the head read");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((pos_ff != '0) && (pos_ff <= n_m1[PW-1:0])))
      else $error("scan position outside the active order");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_cnt_ff != '0))
      else $error("response file count is zero");

endmodule

@@ src/llba_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module llba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ tb/least_loaded_bin_assign_checker.sv @@
`timescale 1ns / 100ps
// Response checker for least_loaded_bin_assign: keeps its own copy of the sorted folder order,
// predicts a placement on every request transfer and compares it on every response transfer.
// Depends on llba_pkg and the channel interfaces in llba_intf.
module least_loaded_bin_assign_checker #(
   parameter int MAX_FOLDERS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [llba_pkg::CFG_W-1:0] csr_wdata,
   llba_req_if                        req,
   llba_rsp_if                        rsp,
   output int unsigned                mismatches,
   output int unsigned                outstanding,
   output int unsigned                checked
);
   import llba_pkg::*;

   typedef struct packed {
      logic [FID_W-1:0]  id;
      logic [LOAD_W-1:0] load;
      logic [CNT_W-1:0]  files;
   } folder_type;

   folder_type  sorted_folders [MAX_FOLDERS];
   int unsigned folders_active;
   folder_type  placement_q [$];
   folder_type  want;
   folder_type  got;
   int unsigned miss_count;
   int unsigned result_count;

   function automatic int unsigned clamp_folders(input logic [CFG_W-1:0] value);
      if (value == '0) return 1;
      if (32'(value) > 32'(MAX_FOLDERS)) return MAX_FOLDERS;
      return 32'(value);
   endfunction

   task automatic restart_order(input logic [CFG_W-1:0] value);
      folders_active = clamp_folders(value);
      for (int i = 0; i < MAX_FOLDERS; i++) begin
         sorted_folders[i].id    = FID_W'(i);
         sorted_folders[i].load  = '0;
         sorted_folders[i].files = '0;
      end
   endtask

   // Head folder takes the file, then moves back to its sorted slot.
   function automatic folder_type place_file(input logic [SIZE_W-1:0] size);
      folder_type      moved;
      logic [LOAD_W:0] sum;
      int unsigned     slot;
      bit              found;
      moved = sorted_folders[0];
      sum = {1'b0, moved.load} + (LOAD_W+1)'(size);
      moved.load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
      if (moved.files != CNT_MAX) moved.files = moved.files + CNT_W'(1);
      slot  = folders_active;
      found = 1'b0;
      for (int unsigned i = 1; i < folders_active; i++) begin
         if (!found && (sorted_folders[i].load > moved.load ||
                        (sorted_folders[i].load == moved.load &&
                         sorted_folders[i].files >= moved.files))) begin
            slot  = i;
            found = 1'b1;
         end
      end
      for (int unsigned i = 1; i < slot; i++) sorted_folders[i-1] = sorted_folders[i];
      sorted_folders[slot-1] = moved;
      return moved;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_order(CFG_W'(16));
         placement_q.delete();
         miss_count   = 0;
         result_count = 0;
      end else begin
         // Compare first so a response in the same cycle as a request cannot match it.
         if (rsp.valid && rsp.ready) begin
            got = {rsp.folder_id, rsp.folder_load, rsp.folder_files};
            result_count++;
            if (placement_q.size() == 0) begin
               if (miss_count < 10)
                  $display("%0t: response with no placement waiting: id %0d load %0d files %0d",
                           $realtime, got.id, got.load, got.files);
               miss_count++;
            end else begin
               want = placement_q.pop_front();
               if (got !== want) begin
                  if (miss_count < 10)
                     $display("%0t: placement mismatch: expected id %0d load %0d files %0d,",
                              $realtime, want.id, want.load, want.files,
                              " got id %0d load %0d files %0d",
                              got.id, got.load, got.files);
                  miss_count++;
               end
            end
         end
         if (csr_we) restart_order(csr_wdata);
         if (req.valid && req.ready) placement_q.push_back(place_file(req.file_size));
      end
      mismatches  <= miss_count;
      checked     <= result_count;
      outstanding <= placement_q.size();
   end

endmodule

@@ tb/least_loaded_bin_assign_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for least_loaded_bin_assign: drives file requests, response back-pressure and
// folder-count writes, and gives the verdict from the checker's counts.
// Depends on llba_pkg, llba_intf, the block and least_loaded_bin_assign_checker.
module least_loaded_bin_assign_tb;
   import llba_pkg::*;

   localparam int unsigned RUN_LIMIT        = 2_000_000;
   localparam int unsigned SETTLE           = 24;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned ONE_FOLDER_FILES = 40;
   localparam int unsigned RAND_PHASES      = 10;
   localparam int unsigned PHASE_FILES      = 100;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;

   llba_req_if req_ch();
   llba_rsp_if rsp_ch();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned checked;
   int unsigned files_sent;
   int unsigned settings_used;
   int unsigned rsp_wait;
   bit          quiet    = 1'b0;
   bit          hold_go  = 1'b0;
   bit          rsp_hold = 1'b0;

   least_loaded_bin_assign dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   least_loaded_bin_assign_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int unsigned draw_gap();
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   // Small sizes keep loads close together so ties come up often.
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return SIZE_W'($urandom_range(0, 3));
      if (roll < 30) return {SIZE_W{1'b0}};
      if (roll < 35) return {SIZE_W{1'b1}};
      return SIZE_W'($urandom());
   endfunction

   function automatic logic [CFG_W-1:0] phase_setting(input int unsigned phase);
      case (phase)
         0: return CFG_W'(16);
         1: return CFG_W'(3);
         2: return CFG_W'(1);
         3: return CFG_W'(8);
         4: return CFG_W'(0);
         5: return CFG_W'(31);
         6: return CFG_W'(5);
         7: return CFG_W'(2);
         9: return CFG_W'(12);
         default: return CFG_W'($urandom_range(0, 31));
      endcase
   endfunction

   // Response side: random stall (may be none) after a transfer; hold off while rsp_hold is set.
   always @(posedge clock) begin : rsp_side
      int unsigned nxt;
      if (reset) begin
         rsp_wait     <= 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) nxt = draw_gap();
         else if (rsp_wait != 0) nxt = rsp_wait - 1;
         else nxt = 0;
         rsp_wait     <= nxt;
         rsp_ch.ready <= (nxt == 0) && !rsp_hold;
      end
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("run limit of %0d cycles reached with %0d placements outstanding",
               RUN_LIMIT, outstanding);
      $display("least_loaded_bin_assign_tb NOT OK");
      $finish;
   end

   // Hold valid high across back-to-back transfers; drop it only for a real gap.
   task automatic send_file(input logic [SIZE_W-1:0] size);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.file_size <= size;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      files_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_folders(input logic [CFG_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.file_size = '0;
      files_sent       = 0;
      settings_used    = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: sixteen folders, zero sizes tie on load, extremes and bit patterns.
      send_file(16'h0000);
      send_file(16'h0000);
      send_file(16'h0000);
      send_file(16'hFFFF);
      send_file(16'hFFFF);
      send_file(16'h0001);
      send_file(16'h8000);
      send_file(16'h5555);
      send_file(16'hAAAA);
      send_file(16'h00FF);
      send_file(16'hFF00);
      send_file(16'h0002);
      send_file(16'h0002);

      // Zero folder count acts as one folder.
      write_folders(5'd0);
      send_file(16'h0007);
      send_file(16'hFFFF);
      send_file(16'h0000);

      // Oversized counts clamp to the full set.
      write_folders(5'd31);
      send_file(16'hFFFF);
      send_file(16'h0001);
      write_folders(5'd17);
      send_file(16'h0003);

      // Two folders with equal sizes: on a load and count tie the updated folder stays at the head.
      write_folders(5'd2);
      repeat (4) send_file(16'h000A);

      // One folder, full sizes, no idling: the same folder takes every file.
      write_folders(5'd1);
      quiet = 1'b1;
      repeat (ONE_FOLDER_FILES) send_file(16'hFFFF);
      quiet = 1'b0;

      for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
         write_folders(phase_setting(ph));
         quiet = (ph != 0) && ($urandom_range(0, 3) == 0);
         for (int unsigned k = 0; k < PHASE_FILES; k++) begin
            if (ph == 0 && k == 40) hold_go = 1'b1;
            if (ph == 2 && k == 50) drain_results();
            send_file(pick_size());
         end
      end
      quiet = 1'b0;

      drain_results();
      $display("placed %0d files, checked %0d responses over %0d folder-count settings",
               files_sent, checked, settings_used);
      $display("covered zero and oversized counts, load ties, one-folder runs, long stall");
      if (mismatches == 0 && outstanding == 0) begin
         $display("least_loaded_bin_assign_tb OK");
      end else begin
         $display("least_loaded_bin_assign_tb NOT OK");
      end
      $finish;
   end

endmodule
